FILE: rtl/armalu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARM ALU package
// Operation codes, flag bit positions and item types shared by the ALU files.
// ----------------------------------------------------------------------------
package armalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_ADC       = 4'd2,
    OP_SBC       = 4'd3,
    OP_RSC       = 4'd4,
    OP_AND       = 4'd5,
    OP_ORR       = 4'd6,
    OP_EOR       = 4'd7,
    OP_BIC       = 4'd8,
    OP_FLAGS     = 4'd9,
    OP_MUL       = 4'd10,
    OP_MLA       = 4'd11,
    OP_UMULL     = 4'd12,
    OP_UMLAL     = 4'd13,
    OP_SMULL     = 4'd14,
    OP_SMLAL     = 4'd15
  } op_t;

  localparam int unsigned FLAG_V = 0;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_N = 3;

  typedef struct packed {
    op_t         operation;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] op_c;
    logic [63:0] acc_in;
    logic [3:0]  flags_in;
  } req_t;

  typedef struct packed {
    logic [63:0] result;
    logic [3:0]  flags_out;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/armalu_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARM ALU channels
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface armalu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] op_c;
  logic [63:0] acc_in;
  logic [3:0]  flags_in;

  modport source (output valid, operation, op_a, op_b, op_c, acc_in, flags_in,
                  input ready);
  modport sink   (input valid, operation, op_a, op_b, op_c, acc_in, flags_in,
                  output ready);
endinterface

interface armalu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic [3:0]  flags_out;

  modport source (output valid, result, flags_out, input ready);
  modport sink   (input valid, result, flags_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/armalu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARM ALU datapath
// Add, subtract, logic, multiply and flags-only ops on one item; NZCV update.
// ----------------------------------------------------------------------------
module armalu_core (
  input  wire armalu_pkg::req_t req,
  output armalu_pkg::rsp_t      rsp
);
  import armalu_pkg::*;

  logic               cin;
  logic               add_cin;
  logic [32:0]        add_sum;
  logic [31:0]        sub_x;
  logic [31:0]        sub_y;
  logic               sub_bin;
  logic [32:0]        sub_diff;
  logic               signed_mul;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic [63:0]        addend;
  logic [63:0]        mac;
  logic [63:0]        res;
  logic [63:0]        nz_val;
  logic               long_op;
  logic               n;
  logic               z;
  logic               c;
  logic               v;

  always_comb begin
    cin      = req.flags_in[FLAG_C];
    add_cin  = (req.operation == OP_ADC) ? cin : 1'b0;
    add_sum  = {1'b0, req.op_a} + {1'b0, req.op_b} + {32'd0, add_cin};

    sub_x    = (req.operation == OP_RSC) ? req.op_b : req.op_a;
    sub_y    = (req.operation == OP_RSC) ? req.op_a : req.op_b;
    sub_bin  = ((req.operation == OP_SBC) || (req.operation == OP_RSC)) ? cin : 1'b0;
    sub_diff = {1'b0, sub_x} - {1'b0, sub_y} - {32'd0, sub_bin};

    signed_mul = (req.operation == OP_SMULL) || (req.operation == OP_SMLAL);
    mul_a      = $signed({signed_mul & req.op_a[31], req.op_a});
    mul_b      = $signed({signed_mul & req.op_b[31], req.op_b});
    prod       = mul_a * mul_b;

    case (req.operation)
      OP_MLA:                addend = {32'd0, req.op_c};
      OP_UMLAL, OP_SMLAL:    addend = req.acc_in;
      default:               addend = 64'd0;
    endcase
    mac = prod[63:0] + addend;

    c       = cin;
    v       = req.flags_in[FLAG_V];
    long_op = 1'b0;
    case (req.operation)
      OP_ADD, OP_ADC: begin
        res = {32'd0, add_sum[31:0]};
        c   = add_sum[32];
        v   = (req.op_a[31] == req.op_b[31]) && (add_sum[31] != req.op_a[31]);
      end
      OP_SUB, OP_SBC, OP_RSC: begin
        res = {32'd0, sub_diff[31:0]};
        c   = sub_diff[32];
        v   = (sub_x[31] != sub_y[31]) && (sub_diff[31] != sub_x[31]);
      end
      OP_AND:   res = {32'd0, req.op_a & req.op_b};
      OP_ORR:   res = {32'd0, req.op_a | req.op_b};
      OP_EOR:   res = {32'd0, req.op_a ^ req.op_b};
      OP_BIC:   res = {32'd0, req.op_a & ~req.op_b};
      OP_FLAGS: res = 64'd0;
      OP_MUL, OP_MLA: res = {32'd0, mac[31:0]};
      OP_UMULL, OP_UMLAL, OP_SMULL, OP_SMLAL: begin
        res     = mac;
        long_op = 1'b1;
      end
      default:  res = 64'd0;
    endcase

    nz_val = (req.operation == OP_FLAGS) ? {32'd0, req.op_a} : res;
    n      = long_op ? nz_val[63] : nz_val[31];
    z      = (nz_val == 64'd0);

    rsp.result             = res;
    rsp.flags_out[FLAG_N]  = n;
    rsp.flags_out[FLAG_Z]  = z;
    rsp.flags_out[FLAG_C]  = c;
    rsp.flags_out[FLAG_V]  = v;
  end

endmodule
`default_nettype wire

FILE: rtl/arm_alu_with_status_flags_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ARM ALU with status flags
// Accepts one item per clock while req.ready is high and returns its result and
// NZCV flags: the item is captured in an input register, passes the
// add/subtract, logic and 33x33 multiply-accumulate datapath, and lands in a
// result register. The multiplier followed by the 64-bit accumulate sets the
// clock period. A stalled result register holds its item while an empty input
// register still takes one new item, so throughput stays at one item per cycle
// whenever the result side keeps taking items.
// ----------------------------------------------------------------------------
module arm_alu_with_status_flags_top (
  input  wire logic     clk,
  input  wire logic     rst,
  armalu_req_if.sink    req,
  armalu_rsp_if.source  rsp
);
  import armalu_pkg::*;

  logic held_valid;
  req_t held;
  logic out_valid;
  rsp_t out_item;
  rsp_t core_rsp;
  logic load_out;

  assign load_out  = !out_valid || rsp.ready;
  assign req.ready = !held_valid || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req.ready) begin
      held_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      held.operation <= op_t'(req.operation);
      held.op_a      <= req.op_a;
      held.op_b      <= req.op_b;
      held.op_c      <= req.op_c;
      held.acc_in    <= req.acc_in;
      held.flags_in  <= req.flags_in;
    end
  end

  armalu_core u_core (
    .req (held),
    .rsp (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= held_valid;
    end
    if (load_out && held_valid) begin
      out_item <= core_rsp;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.result    = out_item.result;
  assign rsp.flags_out = out_item.flags_out;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> held_valid)
    else $error("accepted item not held");

  a_move_to_out: assert property (@(posedge clk) disable iff (rst)
    held_valid && load_out |=> out_valid)
    else $error("held item not moved to result register");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> held_valid && out_valid && !rsp.ready)
    else $error("input stalled without a full pipeline");

  a_keep_vc: assert property (@(posedge clk) disable iff (rst)
    held_valid && held.operation >= OP_AND |->
      core_rsp.flags_out[FLAG_C] == held.flags_in[FLAG_C] &&
      core_rsp.flags_out[FLAG_V] == held.flags_in[FLAG_V])
    else $error("logic or multiply changed C or V");

  a_short_upper_zero: assert property (@(posedge clk) disable iff (rst)
    held_valid && held.operation <= OP_MLA |-> core_rsp.result[63:32] == 32'd0)
    else $error("32-bit operation left upper word set");

endmodule
`default_nettype wire
